/* src/mdp_pkg.sv */
// ----------------------------------------------------------------------------
// mdp_pkg
// Types and constants shared by the Magnus dew point pipeline.
// ----------------------------------------------------------------------------
package mdp_pkg;

  // Request payloads
  typedef struct packed {
    logic signed [10:0] temperature;
    logic [9:0]         humidity;
  } in_req_t;

  typedef struct packed {
    logic signed [10:0] dew_point;
    logic [1:0]         status;
  } out_req_t;

  // Status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_DEW = 2'd1;
  localparam logic [1:0] STATUS_SAT    = 2'd2;

  // Magnus coefficients, scaled by ten
  localparam logic [6:0]  A10_POS = 7'd75;
  localparam logic [6:0]  A10_NEG = 7'd76;
  localparam logic [11:0] B10_POS = 12'd2373;
  localparam logic [11:0] B10_NEG = 12'd2407;

  // Ten times the scaled b coefficient
  localparam logic [14:0] B100_POS = 15'd23730;
  localparam logic [14:0] B100_NEG = 15'd24070;

  // log10(2) in Q.30
  localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;

  // Output limits
  localparam logic signed [10:0] DEW_MAX     = 11'sd800;
  localparam logic signed [10:0] DEW_MIN     = -11'sd1000;
  localparam logic [10:0]        DEW_MAX_MAG = 11'd800;
  localparam logic [10:0]        DEW_MIN_MAG = 11'd1000;

endpackage

/* src/mdp_div.sv */
// ----------------------------------------------------------------------------
// mdp_div
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// ----------------------------------------------------------------------------
module mdp_div #(
  parameter int NW = 33,
  parameter int DW = 16,
  parameter int QB = 19,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int RW = NW + 1;
  localparam int CW = (RW > DW + QB + 1) ? RW : DW + QB + 1;

  logic [CW-1:0] rem_r  [0:QB];
  logic [DW-1:0] den_r  [0:QB];
  logic [QB-1:0] quo_r  [0:QB];
  logic [SW-1:0] side_r [0:QB];
  logic          vld_r  [0:QB];
  logic          ovf_r  [0:QB];

  // Entry stage: add half the divisor for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= CW'(in_num) + CW'(in_den >> 1);
      den_r[0]  <= in_den;
      quo_r[0]  <= '0;
      ovf_r[0]  <= 1'b0;
      side_r[0] <= in_side;
    end
  end

  // One quotient bit per stage, msb first
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    localparam int B = QB - j;
    logic [CW-1:0] dsh;
    logic          ge;
    logic [CW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;
    logic          ovf_nxt;

    always_comb begin
      dsh     = CW'(den_r[j-1]) << B;
      ge      = rem_r[j-1] >= dsh;
      rem_nxt = ge ? rem_r[j-1] - dsh : rem_r[j-1];
      quo_nxt = quo_r[j-1];
      quo_nxt[B] = ge;
      // quotient too large for QB bits
      if (j == 1) begin
        ovf_nxt = rem_r[j-1] >= (CW'(den_r[j-1]) << QB);
      end else begin
        ovf_nxt = ovf_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_r[j-1];
        quo_r[j]  <= quo_nxt;
        ovf_r[j]  <= ovf_nxt;
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quo   = quo_r[QB];
  assign out_ovf   = ovf_r[QB];
  assign out_side  = side_r[QB];

endmodule

/* src/mdp_log2.sv */
// ----------------------------------------------------------------------------
// mdp_log2
// Pipelined fixed-point log2 of a 10-bit value by repeated squaring.
// ----------------------------------------------------------------------------
module mdp_log2 #(
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [9:0]    in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [FB+3:0] out_log,
  output logic [SW-1:0] out_side
);

  logic [30:0]   man_r  [0:FB];
  logic [FB-1:0] frac_r [0:FB];
  logic [3:0]    exp_r  [0:FB];
  logic [SW-1:0] side_r [0:FB];
  logic          vld_r  [0:FB];

  logic [3:0]  exp_nxt;
  logic [30:0] man_nxt;

  // Normalise: msb position and Q1.30 mantissa
  always_comb begin
    exp_nxt = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (in_val[i]) begin
        exp_nxt = 4'(i);
      end
    end
    man_nxt = 31'(in_val) << (5'd30 - 5'(exp_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      man_r[0]  <= man_nxt;
      exp_r[0]  <= exp_nxt;
      frac_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // One fraction bit per stage
  for (genvar j = 1; j <= FB; j++) begin : g_sq
    logic [61:0]   sq;
    logic [31:0]   msq;
    logic          fbit;
    logic [30:0]   man_s;
    logic [FB-1:0] frac_s;

    always_comb begin
      sq     = 62'(man_r[j-1]) * 62'(man_r[j-1]);
      msq    = sq[61:30];
      fbit   = msq[31];
      man_s  = fbit ? msq[31:1] : msq[30:0];
      frac_s = {frac_r[j-1][FB-2:0], fbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        man_r[j]  <= man_s;
        exp_r[j]  <= exp_r[j-1];
        frac_r[j] <= frac_s;
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[FB];
  assign out_log   = {exp_r[FB], frac_r[FB]};
  assign out_side  = side_r[FB];

endmodule

/* src/magnus_dew_point_unit.sv */
// ----------------------------------------------------------------------------
// magnus_dew_point_unit
// Magnus-formula dew point from temperature and relative humidity.
// ----------------------------------------------------------------------------
// Takes one reading per cycle unless the pipe is frozen, and returns one
// result per reading, in order. The pipeline holds the two bit-per-stage
// dividers (FRAC_BITS+4 and 12 stages) and the squaring log2 chain
// (FRAC_BITS+1 stages). A result held at the output freezes the whole pipe,
// so in_ready follows out_ready whenever a result is waiting. Zero humidity
// gives -100.0 C with status 1; results beyond -100.0..80.0 C are clamped
// with status 2.
module magnus_dew_point_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mdp_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mdp_pkg::out_req_t out_data
);

  import mdp_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int N1W = F + 17;
  localparam int Q1W = F + 3;
  localparam int LW  = F + 5;
  localparam int PW  = F + 33;
  localparam int DSW = F + 10;
  localparam int N2W = F + 19;
  localparam int D2W = F + 8;
  localparam int Q2W = 11;

  logic en;

  // Pipe advances unless a finished result is blocked
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // ---- entry stage: coefficients, quotient numerator and divisor ----
  logic        tneg;
  logic [10:0] tmag;
  logic [6:0]  a10_sel;
  logic [11:0] b10_sel;
  logic signed [16:0] bt;
  logic [16:0] absn_nxt;
  logic [15:0] den1_nxt;

  always_comb begin
    tneg     = in_data.temperature[10];
    tmag     = tneg ? (~in_data.temperature + 11'd1) : in_data.temperature;
    a10_sel  = tneg ? A10_NEG : A10_POS;
    b10_sel  = tneg ? B10_NEG : B10_POS;
    absn_nxt = 17'(a10_sel) * 17'(tmag);
    bt       = $signed({5'd0, b10_sel}) + 17'(in_data.temperature);
    den1_nxt = 16'(unsigned'(bt) * 17'd10);
  end

  logic        vld_s0_r;
  logic        neg_s0_r;
  logic        hz_s0_r;
  logic [16:0] absn_s0_r;
  logic [15:0] den1_s0_r;
  logic [9:0]  hum_s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s0_r <= 1'b0;
    end else if (en) begin
      vld_s0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s0_r  <= tneg;
      hz_s0_r   <= (in_data.humidity == 10'd0);
      absn_s0_r <= absn_nxt;
      den1_s0_r <= den1_nxt;
      hum_s0_r  <= in_data.humidity;
    end
  end

  // ---- a*T/(b+T) quotient ----
  logic           v1;
  logic [Q1W-1:0] q1;
  logic [11:0]    side1;

  mdp_div #(
    .NW (N1W),
    .DW (16),
    .QB (Q1W),
    .SW (12)
  ) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_s0_r),
    .in_num    (N1W'(absn_s0_r) << F),
    .in_den    (den1_s0_r),
    .in_side   ({neg_s0_r, hz_s0_r, hum_s0_r}),
    .out_valid (v1),
    .out_quo   (q1),
    .out_ovf   (),
    .out_side  (side1)
  );

  // ---- log2 of humidity ----
  logic           v2;
  logic [F+3:0]   lg;
  logic [Q1W+1:0] side2;

  mdp_log2 #(
    .FB (F),
    .SW (Q1W + 2)
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1),
    .in_val    (side1[9:0]),
    .in_side   ({side1[11:10], q1}),
    .out_valid (v2),
    .out_log   (lg),
    .out_side  (side2)
  );

  // ---- stage M1: signed quotient, log2 * log10(2) ----
  logic signed [LW-1:0] qext;
  logic signed [LW-1:0] qs_nxt;

  always_comb begin
    qext   = $signed(LW'(side2[Q1W-1:0]));
    qs_nxt = side2[Q1W+1] ? -qext : qext;
  end

  logic                 vld_m1_r;
  logic                 neg_m1_r;
  logic                 hz_m1_r;
  logic signed [LW-1:0] qs_m1_r;
  logic [PW-1:0]        prod_m1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m1_r <= 1'b0;
    end else if (en) begin
      vld_m1_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_m1_r  <= side2[Q1W+1];
      hz_m1_r   <= side2[Q1W];
      qs_m1_r   <= qs_nxt;
      prod_m1_r <= PW'(lg) * PW'(LOG10_2_Q30);
    end
  end

  // ---- stage M2: L = quotient + log10(H/1000) ----
  logic [PW-1:0]        prod_rnd;
  logic [F+3:0]         lg10;
  logic signed [LW-1:0] lh;
  logic signed [LW-1:0] l_nxt;

  always_comb begin
    prod_rnd = prod_m1_r + (PW'(1) << 29);
    lg10     = (F + 4)'(prod_rnd >> 30);
    lh       = $signed(LW'(lg10)) - $signed(LW'(3) << F);
    l_nxt    = qs_m1_r + lh;
  end

  logic                 vld_m2_r;
  logic                 neg_m2_r;
  logic                 hz_m2_r;
  logic signed [LW-1:0] l_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m2_r <= 1'b0;
    end else if (en) begin
      vld_m2_r <= vld_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_m2_r <= neg_m1_r;
      hz_m2_r  <= hz_m1_r;
      l_m2_r   <= l_nxt;
    end
  end

  // ---- stage M3: numerator b*L and denominator a - L ----
  logic [14:0]             b100;
  logic signed [LW+15:0]   num_s;
  logic                    num_neg;
  logic [N2W-1:0]          num_mag;
  logic signed [DSW-1:0]   a10f;
  logic signed [DSW-1:0]   l10;
  logic signed [DSW-1:0]   den_s;
  logic                    den_bad;

  always_comb begin
    b100    = neg_m2_r ? B100_NEG : B100_POS;
    num_s   = l_m2_r * $signed({1'b0, b100});
    num_neg = num_s[LW+15];
    num_mag = N2W'(num_neg ? -num_s : num_s);
    a10f    = $signed(DSW'(neg_m2_r ? A10_NEG : A10_POS) << F);
    l10     = l_m2_r * $signed(5'sd10);
    den_s   = a10f - l10;
    den_bad = den_s[DSW-1] || (den_s == '0);
  end

  logic           vld_m3_r;
  logic           hz_m3_r;
  logic           nneg_m3_r;
  logic           dbad_m3_r;
  logic [N2W-1:0] num_m3_r;
  logic [D2W-1:0] den_m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m3_r <= 1'b0;
    end else if (en) begin
      vld_m3_r <= vld_m2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hz_m3_r   <= hz_m2_r;
      nneg_m3_r <= num_neg;
      dbad_m3_r <= den_bad;
      num_m3_r  <= num_mag;
      den_m3_r  <= D2W'(den_s);
    end
  end

  // ---- dew point division ----
  logic           v3;
  logic [Q2W-1:0] q2;
  logic           q2_ovf;
  logic [2:0]     side3;

  mdp_div #(
    .NW (N2W),
    .DW (D2W),
    .QB (Q2W),
    .SW (3)
  ) u_div_dew (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_m3_r),
    .in_num    (num_m3_r),
    .in_den    (den_m3_r),
    .in_side   ({hz_m3_r, nneg_m3_r, dbad_m3_r}),
    .out_valid (v3),
    .out_quo   (q2),
    .out_ovf   (q2_ovf),
    .out_side  (side3)
  );

  // ---- clamp and status ----
  out_req_t out_nxt;

  always_comb begin
    if (side3[2]) begin
      out_nxt.dew_point = DEW_MIN;
      out_nxt.status    = STATUS_NO_DEW;
    end else if (side3[0]) begin
      out_nxt.dew_point = DEW_MAX;
      out_nxt.status    = STATUS_SAT;
    end else if (side3[1]) begin
      if (q2_ovf || (q2 > DEW_MIN_MAG)) begin
        out_nxt.dew_point = DEW_MIN;
        out_nxt.status    = STATUS_SAT;
      end else begin
        out_nxt.dew_point = $signed(~q2 + 11'd1);
        out_nxt.status    = STATUS_OK;
      end
    end else begin
      if (q2_ovf || (q2 > DEW_MAX_MAG)) begin
        out_nxt.dew_point = DEW_MAX;
        out_nxt.status    = STATUS_SAT;
      end else begin
        out_nxt.dew_point = $signed(q2);
        out_nxt.status    = STATUS_OK;
      end
    end
  end

  // Output register
  logic     out_valid_r;
  out_req_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
